### rtl/mnl_pkg.sv
// Shared widths, codes and controller/datapath interface types for the min neighbourhood block.
package mnl_pkg;

   localparam int unsigned POS_W          = 16;
   localparam int unsigned ROAD_W         = 16;
   localparam int unsigned WIDTH_W        = 17;
   localparam int unsigned WIN_W          = 8;
   localparam int unsigned DIST_W         = 18;
   localparam int unsigned STAT_W         = 2;
   localparam int unsigned REQ_DATA_W     = 16;
   localparam int unsigned RSP_DATA_W     = 32;
   localparam int unsigned MAX_CITIES_DEF = 256;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_DUP  = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT_PREP,
      ST_SHIFT,
      ST_AFTER,
      ST_FIND_PREP,
      ST_FIND,
      ST_FINAL,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic full_err;
      logic walk;
      logic dup_err;
      logic shift_init;
      logic shift;
      logic find_init;
      logic find_eval;
      logic find_final;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic dup_hit;
      logic walk_done;
      logic shift_last;
      logic err_set;
      logic last;
      logic rsp_free;
   } sts_type;

endpackage

### rtl/mnl_ctrl.sv
// Controller state machine: sequences store, duplicate scan, insertion shift, cell search and emit.
module mnl_ctrl import mnl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = sts.full ? ST_AFTER : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.dup_hit) begin
               state_in = ST_AFTER;
            end else if (sts.walk_done) begin
               state_in = ST_SHIFT_PREP;
            end
         end
         ST_SHIFT_PREP: state_in = ST_SHIFT;
         ST_SHIFT: begin
            if (sts.shift_last) begin
               state_in = ST_AFTER;
            end
         end
         ST_AFTER: begin
            if (!sts.last) begin
               state_in = ST_IDLE;
            end else if (sts.err_set) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_FIND_PREP;
            end
         end
         ST_FIND_PREP: state_in = ST_FIND;
         ST_FIND: begin
            if (sts.walk_done) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: state_in = ST_EMIT;
         ST_EMIT: begin
            if (sts.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load     = req_tvalid;
            cmd.full_err = req_tvalid & sts.full;
         end
         ST_SCAN: begin
            cmd.walk    = 1'b1;
            cmd.dup_err = sts.dup_hit;
         end
         ST_SHIFT_PREP: cmd.shift_init = 1'b1;
         ST_SHIFT:      cmd.shift      = 1'b1;
         ST_FIND_PREP:  cmd.find_init  = 1'b1;
         ST_FIND: begin
            cmd.walk      = 1'b1;
            cmd.find_eval = 1'b1;
         end
         ST_FINAL: cmd.find_final = 1'b1;
         ST_EMIT:  cmd.emit       = sts.rsp_free;
         default: begin
            cmd        = '0;
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/mnl_dpath.sv
// Datapath: sorted city memory, walk counter, cell width evaluation and result register.
module mnl_dpath import mnl_pkg::*; #(
   parameter int unsigned MAX_CITIES = MAX_CITIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   input  logic                  csr_wr_en,
   input  logic [ROAD_W-1:0]     csr_wr_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [STAT_W-1:0]     rsp_tuser
);

   localparam int unsigned CNT_W = $clog2(MAX_CITIES + 1);
   localparam int unsigned IDX_W = $clog2(MAX_CITIES);
   localparam int unsigned ENT_W = POS_W + IDX_W;

   // entry: arrival id above position
   logic [ENT_W-1:0] mem [MAX_CITIES];

   logic [ROAD_W-1:0]       road_ff, road_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic                    last_ff, last_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   status_type              err_ff, err_in;
   logic [CNT_W-1:0]        k_ff, k_in;
   logic                    rd_valid_ff;
   logic [ENT_W-1:0]        rd_q_ff;
   logic [WIDTH_W-1:0]      lo_ff, lo_in;
   logic signed [DIST_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0]        win_ff, win_in;
   logic                    hit_ff, hit_in;
   logic [POS_W-1:0]        cur_ff, cur_in;
   logic [IDX_W-1:0]        curid_ff, curid_in;
   logic                    have_ff, have_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   status_type              rsp_user_ff, rsp_user_in;

   logic [POS_W-1:0]        rd_pos;
   logic [IDX_W-1:0]        rd_id;
   logic                    walk_issue;
   logic                    shift_move;
   logic                    rd_issue;
   logic [CNT_W-1:0]        rd_addr_full;
   logic [IDX_W-1:0]        rd_addr;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [ENT_W-1:0]        wr_data;
   logic                    eval_en;
   logic [WIDTH_W-1:0]      hi;
   logic signed [DIST_W-1:0] w;
   logic                    better;
   logic [WIDTH_W-1:0]      width_clamp;
   logic [IDX_W+WIN_W-1:0]  win_ext;

   assign rd_pos     = rd_q_ff[POS_W-1:0];
   assign rd_id      = rd_q_ff[ENT_W-1:POS_W];
   assign walk_issue = cmd.walk && (k_ff < count_ff);
   assign shift_move = cmd.shift && rd_valid_ff && (rd_pos > pos_ff);

   // read port select: forward walk, top entry, or entry below the hole
   always_comb begin
      rd_issue     = 1'b0;
      rd_addr_full = k_ff;
      if (walk_issue) begin
         rd_issue = 1'b1;
      end else if (cmd.shift_init && (count_ff != '0)) begin
         rd_issue     = 1'b1;
         rd_addr_full = count_ff - CNT_W'(1);
      end else if (shift_move && (k_ff >= CNT_W'(2))) begin
         rd_issue     = 1'b1;
         rd_addr_full = k_ff - CNT_W'(2);
      end
   end
   assign rd_addr = rd_addr_full[IDX_W-1:0];

   assign wr_en   = cmd.shift;
   assign wr_addr = k_ff[IDX_W-1:0];
   assign wr_data = shift_move ? rd_q_ff : {count_ff[IDX_W-1:0], pos_ff};

   assign eval_en = have_ff && ((cmd.find_eval && rd_valid_ff) || cmd.find_final);
   assign hi      = cmd.find_final ? {road_ff, 1'b0}
                                   : (WIDTH_W'(cur_ff) + WIDTH_W'(rd_pos));
   assign w       = $signed({1'b0, hi}) - $signed({1'b0, lo_ff});
   assign better  = w < best_ff;

   assign width_clamp = best_ff[DIST_W-1] ? '0 : best_ff[WIDTH_W-1:0];
   assign win_ext     = {{WIN_W{1'b0}}, win_ff};

   always_comb begin
      road_in      = road_ff;
      pos_in       = pos_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      k_in         = k_ff;
      lo_in        = lo_ff;
      best_in      = best_ff;
      win_in       = win_ff;
      hit_in       = hit_ff;
      cur_in       = cur_ff;
      curid_in     = curid_ff;
      have_in      = have_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      if (csr_wr_en) begin
         road_in = csr_wr_data;
      end
      if (cmd.load) begin
         pos_in  = req_tdata[POS_W-1:0];
         last_in = req_tlast;
         k_in    = '0;
      end
      if ((cmd.full_err || cmd.dup_err) && (err_ff == STATUS_OK)) begin
         err_in = cmd.full_err ? STATUS_FULL : STATUS_DUP;
      end
      if (walk_issue) begin
         k_in = k_ff + CNT_W'(1);
      end
      if (cmd.shift_init) begin
         k_in = count_ff;
      end
      if (cmd.shift) begin
         if (shift_move) begin
            k_in = k_ff - CNT_W'(1);
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      if (cmd.find_init) begin
         k_in    = '0;
         lo_in   = '0;
         best_in = $signed(DIST_W'({road_ff, 1'b0}));
         win_in  = '0;
         hit_in  = 1'b0;
         have_in = 1'b0;
      end
      if (eval_en) begin
         lo_in = hi;
         if (better) begin
            best_in = w;
            win_in  = curid_ff;
            hit_in  = 1'b1;
         end
      end
      if (cmd.find_eval && rd_valid_ff) begin
         cur_in   = rd_pos;
         curid_in = rd_id;
         have_in  = 1'b1;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = err_ff;
         if (err_ff == STATUS_OK) begin
            rsp_data_in = RSP_DATA_W'({hit_ff, win_ext[WIN_W-1:0], width_clamp});
         end else begin
            rsp_data_in = '0;
         end
         count_in = '0;
         err_in   = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         road_ff      <= '0;
         count_ff     <= '0;
         err_ff       <= STATUS_OK;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         road_ff      <= road_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rd_valid_ff  <= rd_issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      last_ff     <= last_in;
      k_ff        <= k_in;
      lo_ff       <= lo_in;
      best_ff     <= best_in;
      win_ff      <= win_in;
      hit_ff      <= hit_in;
      cur_ff      <= cur_in;
      curid_ff    <= curid_in;
      have_ff     <= have_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_issue) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   assign sts.full       = (count_ff == CNT_W'(MAX_CITIES));
   assign sts.dup_hit    = rd_valid_ff && (rd_pos == pos_ff);
   assign sts.walk_done  = !(k_ff < count_ff) && !rd_valid_ff;
   assign sts.shift_last = !(rd_valid_ff && (rd_pos > pos_ff));
   assign sts.err_set    = (err_ff != STATUS_OK);
   assign sts.last       = last_ff;
   assign sts.rsp_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### rtl/min_neighbourhood_on_line.sv
// Top level of the smallest 1D Voronoi cell finder: controller plus datapath.
//
// Usage: write the road length through csr_wr_en/csr_wr_data while idle, then
// stream city positions on the req_ channel, one word each, with req_tlast on
// the final city of a set. Positions are kept sorted in a two-port memory;
// a repeated position or a city past MAX_CITIES is flagged and not stored.
// Only the marked word produces a result word on the rsp_ channel: smallest
// cell width in half units, arrival index of the winner, a found flag, and a
// status code in rsp_tuser (ok, duplicate, too many cities; on error the
// data fields are zero). Count and error clear after each set.
// Timing: one word at a time. Each word runs an upward duplicate scan, then a
// downward insertion shift, one memory read per cycle; a marked word adds the
// cell walk, again set by the single memory read port. Reset clears the city
// count, the error, the road length and any pending result. A finished result
// waits in an output register while new words are taken; a marked word stalls
// in its last step until that register is free.
module min_neighbourhood_on_line import mnl_pkg::*; #(
   parameter int unsigned MAX_CITIES = MAX_CITIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [15:0] city_position
   input  logic                  req_tlast,   // last_city
   input  logic                  csr_wr_en,
   input  logic [ROAD_W-1:0]     csr_wr_data, // road_length
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [16:0] min_width_halves, [24:17] winner_index,
                                              // [25] found, [31:26] zero
   output logic [STAT_W-1:0]     rsp_tuser    // [1:0] status
);

   cmd_type cmd;
   sts_type sts;

   // sequence each word through store, search and emit
   mnl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // hold the sorted cities and compute cell widths
   mnl_dpath #(
      .MAX_CITIES (MAX_CITIES)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

### dv/tb_min_neighbourhood_on_line.sv
// Self-checking testbench for min_neighbourhood_on_line: city stream in, smallest cell out.
module tb_min_neighbourhood_on_line;
   import mnl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CITY_CAP      = MAX_CITIES_DEF;
   // Settling time for the store of one word plus the cell walk of a marked word, with margin.
   localparam int unsigned SETTLE_CYCLES = 3 * CITY_CAP + 16;
   localparam int unsigned RAND_PHASES   = 4;
   localparam int unsigned PHASE_CITIES  = 10;

   // Expected outcome of one marked word, field by field.
   typedef struct {
      logic [WIDTH_W-1:0] width;
      logic [WIN_W-1:0]   winner;
      logic               found;
      status_type         status;
   } cell_result_type;

   // Receiver behavior, switched every so often.
   typedef enum int unsigned {RX_OPEN, RX_COIN, RX_TRICKLE, RX_MOSTLY} rx_mode_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;   // [15:0] city_position
   logic                  req_tlast   = 1'b0; // last_city
   logic                  csr_wr_en   = 1'b0;
   logic [ROAD_W-1:0]     csr_wr_data = '0;   // road_length
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // [16:0] width, [24:17] winner, [25] found
   logic [STAT_W-1:0]     rsp_tuser;          // [1:0] status

   // Shadow of the block: sorted positions with arrival ids, count, held error, road.
   int               kept_pos [CITY_CAP];
   logic [WIN_W-1:0] kept_id  [CITY_CAP];
   int unsigned      kept_count = 0;
   status_type       held_err   = STATUS_OK;
   logic [ROAD_W-1:0] road_len  = '0;

   cell_result_type pending_cells[$];
   int unsigned     fault_count = 0;
   int unsigned     burst_left  = 0;
   int unsigned     rx_tick     = 0;
   rx_mode_type     rx_mode     = RX_OPEN;

   min_neighbourhood_on_line dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always #10 clock = ~clock;

   // Report the first few faults in full, count the rest.
   task automatic note_fault(input string msg);
      if (fault_count < 10) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      fault_count++;
   endtask

   // Walk the sorted cities and pick the first strictly smaller cell, in half units.
   function automatic cell_result_type smallest_cell();
      cell_result_type res;
      int best;
      int lo;
      int hi;
      int w;
      best       = 2 * int'(road_len);
      res.winner = '0;
      res.found  = 1'b0;
      res.status = STATUS_OK;
      for (int i = 0; i < int'(kept_count); i++) begin
         lo = (i == 0) ? 0 : kept_pos[i] + kept_pos[i-1];
         hi = (i + 1 >= int'(kept_count)) ? 2 * int'(road_len) : kept_pos[i] + kept_pos[i+1];
         w  = hi - lo;
         if (w < best) begin
            best       = w;
            res.winner = kept_id[i];
            res.found  = 1'b1;
         end
      end
      // A city past the road end can make the winning width negative: clamp it.
      if (best < 0) begin
         best = 0;
      end
      res.width = best[WIDTH_W-1:0];
      return res;
   endfunction

   // Update the shadow for one accepted word; queue a result on a marked word.
   task automatic absorb_city(input logic [POS_W-1:0] pos, input logic last);
      cell_result_type res;
      int  k;
      bit  dup;
      dup = 1'b0;
      if (kept_count >= CITY_CAP) begin
         if (held_err == STATUS_OK) begin
            held_err = STATUS_FULL;
         end
      end else begin
         for (int i = 0; i < int'(kept_count); i++) begin
            if (kept_pos[i] == int'(pos)) begin
               dup = 1'b1;
            end
         end
         if (dup) begin
            if (held_err == STATUS_OK) begin
               held_err = STATUS_DUP;
            end
         end else begin
            k = kept_count;
            while (k > 0 && kept_pos[k-1] > int'(pos)) begin
               kept_pos[k] = kept_pos[k-1];
               kept_id[k]  = kept_id[k-1];
               k--;
            end
            kept_pos[k] = int'(pos);
            kept_id[k]  = kept_count[WIN_W-1:0];
            kept_count++;
         end
      end
      if (last) begin
         if (held_err != STATUS_OK) begin
            res.width  = '0;
            res.winner = '0;
            res.found  = 1'b0;
            res.status = held_err;
         end else begin
            res = smallest_cell();
         end
         pending_cells.push_back(res);
         kept_count = 0;
         held_err   = STATUS_OK;
      end
   endtask

   // Offer one word; the sender runs in bursts with random gaps between them.
   task automatic send_city(input logic [POS_W-1:0] pos, input logic last);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 40);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pos;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      absorb_city(pos, last);
   endtask

   // Send a whole set, marking the final city.
   task automatic send_set(input logic [POS_W-1:0] cities[$]);
      foreach (cities[i]) begin
         send_city(cities[i], i == cities.size() - 1);
      end
   endtask

   // Hold the sender until every expected result is back, then let the block settle.
   task automatic wait_all_cells();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the road length, only once the block has gone idle.
   task automatic set_road(input logic [ROAD_W-1:0] len);
      wait_all_cells();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      road_len = len;
   endtask

   // Single city, equal cells (first in position order wins), unsorted arrival.
   task automatic test_lone_and_tied_cells();
      set_road(16'd100);
      send_set('{16'd50});
      send_set('{16'd25, 16'd75});
      send_set('{16'd80, 16'd10, 16'd30});
   endtask

   // Repeated position mid-set and on the marked word itself.
   task automatic test_duplicate_positions();
      send_set('{16'd5, 16'd5, 16'd7});
      send_set('{16'd9, 16'd9});
   endtask

   // Cities past the road end give negative cells; with a zero road the last cell is never positive.
   task automatic test_cities_past_road_end();
      send_set('{16'd0, 16'hFFFF});
      set_road(16'd0);
      send_set('{16'd5, 16'd10});
      send_set('{16'd0});
   endtask

   // Full road length: widest possible cell and position extremes.
   task automatic test_extreme_lengths();
      set_road(16'hFFFF);
      send_set('{16'd0, 16'hFFFF});
      send_set('{16'h8000});
      send_set('{16'hFFFF, 16'h7FFF, 16'd1});
   endtask

   // Distinct positions by an odd stride; optionally repeat the first one up front.
   task automatic send_spread_set(input int unsigned n_cities, input bit lead_dup);
      logic [POS_W-1:0] start;
      logic [POS_W-1:0] stride;
      start  = POS_W'($urandom);
      stride = POS_W'($urandom | 1);
      if (lead_dup) begin
         send_city(start, 1'b0);
      end
      for (int unsigned i = 0; i < n_cities; i++) begin
         send_city(start + POS_W'(i) * stride, i == n_cities - 1);
      end
   endtask

   // Exactly full, one past full, and a duplicate held through an overflow.
   task automatic test_full_city_table();
      set_road(16'($urandom_range(32768, 65535)));
      send_spread_set(CITY_CAP, 1'b0);
      send_spread_set(CITY_CAP + 1, 1'b0);
      send_spread_set(CITY_CAP + 1, 1'b1);
   endtask

   // Random sets across several road lengths, mostly well-formed, some with repeats.
   task automatic test_random_sets();
      logic [POS_W-1:0]  used[$];
      logic [POS_W-1:0]  pos;
      logic [ROAD_W-1:0] len;
      int unsigned total;
      int unsigned pick;
      int unsigned set_len;
      int unsigned dup_at;
      bit          wide;
      for (int p = 0; p < int'(RAND_PHASES); p++) begin
         case (p)
            0:       len = 16'hFFFF;
            1:       len = 16'h0000;
            2:       len = 16'($urandom_range(1, 300));
            default: len = 16'($urandom);
         endcase
         set_road(len);
         total = 0;
         while (total < PHASE_CITIES) begin
            pick    = $urandom_range(0, 99);
            set_len = (pick < 75) ? $urandom_range(1, 10) :
                      (pick < 95) ? $urandom_range(11, 40) : $urandom_range(41, 120);
            // Zero means no planted repeat; index 0 can never repeat anything.
            dup_at  = (set_len > 1 && $urandom_range(0, 7) == 0) ?
                      $urandom_range(1, set_len - 1) : 0;
            // Short roads cannot hold many distinct cities: draw from the full range.
            wide    = int'(road_len) < 2 * int'(set_len);
            used.delete();
            for (int unsigned i = 0; i < set_len; i++) begin
               if (i != 0 && i == dup_at) begin
                  pos = used[$urandom_range(0, used.size() - 1)];
               end else if (wide || $urandom_range(0, 9) == 0) begin
                  pos = POS_W'($urandom);
               end else begin
                  pos = POS_W'($urandom_range(0, road_len));
               end
               used.push_back(pos);
               send_city(pos, i == set_len - 1);
            end
            total += set_len;
            if ($urandom_range(0, 24) == 0) begin
               wait_all_cells();
            end
         end
      end
   endtask

   // Receiver: switch among stall modes, including stretches with no stall.
   always @(posedge clock) begin
      rx_tick <= rx_tick + 1;
      if (rx_tick % 97 == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
      end
      case (rx_mode)
         RX_OPEN:    rsp_tready <= 1'b1;
         RX_COIN:    rsp_tready <= 1'($urandom_range(0, 1));
         RX_TRICKLE: rsp_tready <= (rx_tick % 9 == 0);
         default:    rsp_tready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // Compare each accepted result word with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      cell_result_type seen;
      cell_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.width  = rsp_tdata[WIDTH_W-1:0];
         seen.winner = rsp_tdata[WIDTH_W +: WIN_W];
         seen.found  = rsp_tdata[WIDTH_W + WIN_W];
         seen.status = status_type'(rsp_tuser);
         if (pending_cells.size() == 0) begin
            note_fault($sformatf("unexpected word width=%0d winner=%0d found=%0b status=%0d",
                                 seen.width, seen.winner, seen.found, seen.status));
         end else begin
            want = pending_cells.pop_front();
            if (seen.width !== want.width) begin
               note_fault($sformatf("width exp %0d got %0d", want.width, seen.width));
            end
            if (seen.winner !== want.winner) begin
               note_fault($sformatf("winner exp %0d got %0d", want.winner, seen.winner));
            end
            if (seen.found !== want.found) begin
               note_fault($sformatf("found exp %0b got %0b", want.found, seen.found));
            end
            if (seen.status !== want.status) begin
               note_fault($sformatf("status exp %0d got %0d", want.status, seen.status));
            end
         end
      end
   end

   // Run the tests in turn; drain and report at the end.
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_lone_and_tied_cells();
      test_duplicate_positions();
      test_cities_past_road_end();
      test_extreme_lengths();
      test_full_city_table();
      test_random_sets();
      wait_all_cells();
      if (fault_count == 0 && pending_cells.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of this stimulus.
   initial begin
      #80_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
